>>> design/wall_view_transform_project_top_defines.svh
// Assertion helpers for the wall view transform block.
`ifndef WALL_VIEW_TRANSFORM_PROJECT_TOP_DEFINES_SVH
`define WALL_VIEW_TRANSFORM_PROJECT_TOP_DEFINES_SVH
// same-cycle implication, off during reset
`define WVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, off during reset
`define WVT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
// next-cycle implication, always on
`define WVT_ASSERT_ALW(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`endif

>>> design/wvt_pkg.sv
package wvt_pkg;

  localparam int XW         = 20;  // camera-space x and depth
  localparam int ZW         = 24;  // bottom and top heights
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [CFG_AW-1:0] {
    REG_CAM_X     = 3'd0,
    REG_CAM_Y     = 3'd1,
    REG_CAM_Z     = 3'd2,
    REG_VIEW_COS  = 3'd3,
    REG_VIEW_SIN  = 3'd4,
    REG_PITCH     = 3'd5,
    REG_FLOOR     = 3'd6,
    REG_HEIGHT    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] cam_x;
    logic signed [15:0] cam_y;
    logic signed [15:0] cam_z;
    logic signed [15:0] view_cos;
    logic signed [15:0] view_sin;
    logic signed [7:0]  look_pitch;
    logic signed [15:0] sector_floor;
    logic signed [15:0] sector_height;
  } cfg_t;

  // one transformed wall, index 0 is the start point, or the end point on a back pass
  typedef struct packed {
    logic                  culled;
    logic [1:0][XW-1:0]    px;
    logic [1:0][XW-1:0]    py;
    logic [1:0][ZW-1:0]    zb;
    logic [1:0][ZW-1:0]    zt;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

>>> design/wall_view_transform_project_top.sv
// Wall view transform and projection: one wall segment per cycle sustained while the output is not stalled.
// Path from acceptance to result valid: 6 front stages, the queue, and 87 back stages,
// most of them the two bit-per-stage divider pipelines (clip factor and perspective
// divide).
// Reset (rst_n low, synchronous) empties the pipelines and the queue and
// loads the camera registers with their defaults.
`include "wall_view_transform_project_top_defines.svh"

module wall_view_transform_project_top #(
  parameter int HALF_WIDTH  = 80,
  parameter int HALF_HEIGHT = 60
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [wvt_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [wvt_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [15:0]           in_start_x,
  input  logic signed [15:0]           in_start_y,
  input  logic signed [15:0]           in_end_x,
  input  logic signed [15:0]           in_end_y,
  input  logic                         in_back_pass,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_culled,
  output logic signed [15:0]           out_screen_x_left,
  output logic signed [15:0]           out_screen_x_right,
  output logic signed [15:0]           out_bottom_y_left,
  output logic signed [15:0]           out_bottom_y_right,
  output logic signed [15:0]           out_top_y_left,
  output logic signed [15:0]           out_top_y_right
);

  wvt_pkg::cfg_t       cfg_r;
  wvt_pkg::fifo_stat_t fifo_st;
  wvt_pkg::item_t      f_item;
  wvt_pkg::item_t      q_head;
  logic                push;
  logic                pop;
  logic                out_zero;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cam_x         <= 16'sd0;
      cfg_r.cam_y         <= 16'sd0;
      cfg_r.cam_z         <= 16'sd0;
      cfg_r.view_cos      <= 16'sd16384;
      cfg_r.view_sin      <= 16'sd0;
      cfg_r.look_pitch    <= 8'sd0;
      cfg_r.sector_floor  <= 16'sd0;
      cfg_r.sector_height <= 16'sd40;
    end else if (cfg_valid && cfg_ready) begin
      case (wvt_pkg::cfg_reg_t'(cfg_index))
        wvt_pkg::REG_CAM_X:    cfg_r.cam_x         <= cfg_wdata;
        wvt_pkg::REG_CAM_Y:    cfg_r.cam_y         <= cfg_wdata;
        wvt_pkg::REG_CAM_Z:    cfg_r.cam_z         <= cfg_wdata;
        wvt_pkg::REG_VIEW_COS: cfg_r.view_cos      <= cfg_wdata;
        wvt_pkg::REG_VIEW_SIN: cfg_r.view_sin      <= cfg_wdata;
        wvt_pkg::REG_PITCH:    cfg_r.look_pitch    <= cfg_wdata[7:0];
        wvt_pkg::REG_FLOOR:    cfg_r.sector_floor  <= cfg_wdata;
        wvt_pkg::REG_HEIGHT:   cfg_r.sector_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  wvt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .in_end_x     (in_end_x),
    .in_end_y     (in_end_y),
    .in_back_pass (in_back_pass),
    .fifo_st      (fifo_st),
    .push         (push),
    .item         (f_item)
  );

  wvt_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (f_item),
    .pop   (pop),
    .rdata (q_head),
    .st    (fifo_st)
  );

  wvt_back #(.HALF_WIDTH(HALF_WIDTH), .HALF_HEIGHT(HALF_HEIGHT)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .fifo_st            (fifo_st),
    .head               (q_head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_culled         (out_culled),
    .out_screen_x_left  (out_screen_x_left),
    .out_screen_x_right (out_screen_x_right),
    .out_bottom_y_left  (out_bottom_y_left),
    .out_bottom_y_right (out_bottom_y_right),
    .out_top_y_left     (out_top_y_left),
    .out_top_y_right    (out_top_y_right)
  );

  assign out_zero = (out_screen_x_left == 16'sd0) && (out_screen_x_right == 16'sd0) &&
                    (out_bottom_y_left == 16'sd0) && (out_bottom_y_right == 16'sd0) &&
                    (out_top_y_left == 16'sd0) && (out_top_y_right == 16'sd0);

  `WVT_ASSERT_IMP(a_culled_zero, clk, rst_n, out_valid && out_culled, out_zero, "culled transaction carries nonzero fields")
  `WVT_ASSERT_NXT(a_push_fill, clk, rst_n, push && !pop, !fifo_st.empty, "queue empty after unmatched push")
  `WVT_ASSERT_ALW(a_reset_idle, clk, !rst_n, !out_valid && !in_stall && fifo_st.empty, "block not idle after reset")

endmodule

>>> design/wvt_div.sv
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// Lanes share the control pipeline.
module wvt_div #(
  parameter int LN = 1,
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int SW = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  logic [LN-1:0][NW-1:0] num_i,
  input  logic [LN-1:0][DW-1:0] den_i,
  input  logic [SW-1:0]         side_i,
  output logic                  vld_o,
  output logic [LN-1:0][NW:0]   quo_o,
  output logic [SW-1:0]         side_o
);

  localparam int RW = DW + 1;
  localparam int NS = NW + 1;
  localparam int QW = NW + 1;

  logic [NW-1:0]       nq_r [NS][LN];
  logic [DW-1:0]       dv_r [NS][LN];
  logic [DW-1:0]       rm_r [NS][LN];
  logic                ng_r [NS][LN];
  logic [SW-1:0]       sd_r [NS];
  logic [NS:0]         vl_r;
  logic [LN-1:0][NW:0] quo_r;
  logic [SW-1:0]       side_r;

  function automatic logic [DW+NW-1:0] step(input logic [DW-1:0] rm,
                                            input logic [NW-1:0] nq,
                                            input logic [DW-1:0] dv);
    logic [RW-1:0] tr;
    logic [RW-1:0] df;
    logic          qb;
    tr = {rm, nq[NW-1]};
    df = tr - {1'b0, dv};
    qb = (tr >= {1'b0, dv});
    return {(qb ? df[DW-1:0] : tr[DW-1:0]), nq[NW-2:0], qb};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r <= '0;
    end else if (en) begin
      vl_r <= {vl_r[NS-1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= side_i;
      for (int l = 0; l < LN; l++) begin
        nq_r[0][l] <= num_i[l][NW-1] ? NW'(~num_i[l] + 1'b1) : num_i[l];
        dv_r[0][l] <= den_i[l][DW-1] ? DW'(~den_i[l] + 1'b1) : den_i[l];
        rm_r[0][l] <= '0;
        ng_r[0][l] <= num_i[l][NW-1] ^ den_i[l][DW-1];
      end
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        sd_r[s] <= sd_r[s-1];
        for (int l = 0; l < LN; l++) begin
          dv_r[s][l] <= dv_r[s-1][l];
          ng_r[s][l] <= ng_r[s-1][l];
          {rm_r[s][l], nq_r[s][l]} <= step(rm_r[s-1][l], nq_r[s-1][l], dv_r[s-1][l]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= sd_r[NW];
      for (int l = 0; l < LN; l++) begin
        quo_r[l] <= ng_r[NW][l] ? QW'(~{1'b0, nq_r[NW][l]} + 1'b1) : {1'b0, nq_r[NW][l]};
      end
    end
  end

  assign vld_o  = vl_r[NS];
  assign quo_o  = quo_r;
  assign side_o = side_r;

endmodule

>>> design/wvt_front.sv
// Front: camera translate, rotate, heights and cull classification. Six stages.
module wvt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  wvt_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  in_start_x,
  input  logic signed [15:0]  in_start_y,
  input  logic signed [15:0]  in_end_x,
  input  logic signed [15:0]  in_end_y,
  input  logic                in_back_pass,
  input  wvt_pkg::fifo_stat_t fifo_st,
  output logic                push,
  output wvt_pkg::item_t      item
);

  localparam int XW = wvt_pkg::XW;
  localparam int ZW = wvt_pkg::ZW;

  logic                 en;
  logic [5:0]           v_r;
  logic signed [16:0]   ax_r [2];
  logic signed [16:0]   ay_r [2];
  logic signed [32:0]   mxc_r [2];
  logic signed [32:0]   mys_r [2];
  logic signed [32:0]   myc_r [2];
  logic signed [32:0]   mxs_r [2];
  logic signed [XW-1:0] px2_r [2];
  logic signed [XW-1:0] py2_r [2];
  logic signed [XW-1:0] px3_r [2];
  logic signed [XW-1:0] py3_r [2];
  logic signed [27:0]   pr3_r [2];
  logic signed [XW-1:0] px4_r [2];
  logic signed [XW-1:0] py4_r [2];
  logic signed [ZW-1:0] zb4_r [2];
  wvt_pkg::item_t       item_r;
  logic signed [16:0]   fz;
  logic signed [21:0]   zbase;

  function automatic logic signed [XW-1:0] div14(input logic signed [33:0] s);
    logic signed [33:0] b;
    b = s + (s[33] ? 34'sd16383 : 34'sd0);
    return b[33:14];
  endfunction

  function automatic logic signed [ZW-1:0] div5(input logic signed [28:0] s);
    logic signed [28:0] b;
    b = s + (s[28] ? 29'sd31 : 29'sd0);
    return b[28:5];
  endfunction

  assign en       = !v_r[5] || !fifo_st.full;
  assign in_stall = !en;
  assign push     = v_r[5] && !fifo_st.full;
  assign item     = item_r;
  assign fz       = 17'($signed(cfg.sector_floor)) - 17'($signed(cfg.cam_z));
  assign zbase    = {fz, 5'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r[0] <= 17'(in_back_pass ? in_end_x : in_start_x) - 17'($signed(cfg.cam_x));
      ay_r[0] <= 17'(in_back_pass ? in_end_y : in_start_y) - 17'($signed(cfg.cam_y));
      ax_r[1] <= 17'(in_back_pass ? in_start_x : in_end_x) - 17'($signed(cfg.cam_x));
      ay_r[1] <= 17'(in_back_pass ? in_start_y : in_end_y) - 17'($signed(cfg.cam_y));
      for (int e = 0; e < 2; e++) begin
        mxc_r[e] <= ax_r[e] * $signed(cfg.view_cos);
        mys_r[e] <= ay_r[e] * $signed(cfg.view_sin);
        myc_r[e] <= ay_r[e] * $signed(cfg.view_cos);
        mxs_r[e] <= ax_r[e] * $signed(cfg.view_sin);
        px2_r[e] <= div14(mxc_r[e] - mys_r[e]);
        py2_r[e] <= div14(myc_r[e] + mxs_r[e]);
        px3_r[e] <= px2_r[e];
        py3_r[e] <= py2_r[e];
        pr3_r[e] <= py2_r[e] * $signed(cfg.look_pitch);
        px4_r[e] <= px3_r[e];
        py4_r[e] <= py3_r[e];
        zb4_r[e] <= div5(29'(zbase) + 29'(pr3_r[e]));
        item_r.px[e] <= px4_r[e];
        item_r.py[e] <= py4_r[e];
        item_r.zb[e] <= zb4_r[e];
        item_r.zt[e] <= zb4_r[e] + ZW'($signed(cfg.sector_height));
      end
      item_r.culled <= (py4_r[0] < 1) && (py4_r[1] < 1);
    end
  end

endmodule

>>> design/wvt_fifo.sv
// Small queue between front and back. The head entry is registered.
module wvt_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  wvt_pkg::item_t       wdata,
  input  logic                 pop,
  output wvt_pkg::item_t       rdata,
  output wvt_pkg::fifo_stat_t  st
);

  localparam int AW = wvt_pkg::FIFO_AW;

  wvt_pkg::item_t mem_r [wvt_pkg::FIFO_DEPTH];
  wvt_pkg::item_t rdata_r;
  logic [AW-1:0]  wp_r;
  logic [AW-1:0]  rp_r;
  logic [AW-1:0]  rp_nxt;
  logic [AW:0]    cnt_r;

  assign rp_nxt = pop ? rp_r + 1'b1 : rp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      rp_r <= rp_nxt;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // write-through when the new head slot is written in the same cycle
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
    rdata_r <= (push && (wp_r == rp_nxt)) ? wdata : mem_r[rp_nxt];
  end

  assign rdata    = rdata_r;
  assign st.full  = (cnt_r == (AW+1)'(wvt_pkg::FIFO_DEPTH));
  assign st.empty = (cnt_r == '0);

endmodule

>>> design/wvt_back.sv
// Back: near clip of one endpoint, perspective divide, saturation.
module wvt_back #(
  parameter int HALF_WIDTH  = 80,
  parameter int HALF_HEIGHT = 60
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wvt_pkg::fifo_stat_t fifo_st,
  input  wvt_pkg::item_t      head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_culled,
  output logic signed [15:0]  out_screen_x_left,
  output logic signed [15:0]  out_screen_x_right,
  output logic signed [15:0]  out_bottom_y_left,
  output logic signed [15:0]  out_bottom_y_right,
  output logic signed [15:0]  out_top_y_left,
  output logic signed [15:0]  out_top_y_right
);

  localparam int XW   = wvt_pkg::XW;
  localparam int ZW   = wvt_pkg::ZW;
  localparam int BW   = ZW + 1;       // b - a
  localparam int DDW  = XW + 1;       // clip divisor
  localparam int PW   = ZW + DDW + 1; // clip numerator
  localparam int NNW  = ZW + 8;       // value * 200
  localparam int SATW = NNW + 2;
  localparam logic signed [NNW-1:0]  SCALE  = NNW'(200);
  localparam logic signed [SATW-1:0] HW_EXT = SATW'(HALF_WIDTH);
  localparam logic signed [SATW-1:0] HH_EXT = SATW'(HALF_HEIGHT);

  typedef struct packed {
    wvt_pkg::item_t it;
    logic           sel;
    logic           clip;
  } clip_side_t;

  logic                  en;
  logic                  out_valid_r;
  logic [2:0]            bv_r;

  logic                  clip0, clip1, sel_c, doclip_c;
  logic signed [ZW-1:0]  a_c [3];
  logic signed [ZW-1:0]  b_c [3];
  logic signed [DDW-1:0] da_c, db_c, dd_c;

  clip_side_t            s0_r, s1_r, s2_r;
  logic signed [ZW-1:0]  a0_r [3];
  logic signed [BW-1:0]  bma0_r [3];
  logic signed [DDW-1:0] da0_r, d0_r, d1_r, d2_r;
  logic signed [PW-1:0]  p1_r [3];
  logic signed [PW-1:0]  p2_r [3];
  logic signed [PW-1:0]  num_r [3];

  logic [2:0][PW-1:0]    num_d;
  logic [2:0][DDW-1:0]   den_d;
  logic                  cd_v;
  logic [2:0][PW:0]      cq;
  logic [$bits(clip_side_t)-1:0] cs_raw;
  clip_side_t            cs;

  logic signed [ZW-1:0]  vx [2];
  logic signed [ZW-1:0]  vb [2];
  logic signed [ZW-1:0]  vt [2];
  logic signed [XW-1:0]  vy [2];
  logic [5:0][NNW-1:0]   pn_r;
  logic [5:0][XW-1:0]    pd_r;
  logic                  pc3_r;
  logic                  b3v_r;

  logic                  pv;
  logic [5:0][NNW:0]     pq;
  logic                  pc;
  logic                  oc_r;
  logic signed [15:0]    o_r [6];

  function automatic logic signed [15:0] sat16(input logic signed [SATW-1:0] v);
    if (v > SATW'(32767)) return 16'sh7fff;
    else if (v < -SATW'(32768)) return 16'sh8000;
    else return v[15:0];
  endfunction

  assign en  = !out_valid_r || !out_stall;
  assign pop = en && !fifo_st.empty;

  // at most one endpoint is behind when the wall is not culled
  always_comb begin
    clip0    = $signed(head.py[0]) < 1;
    clip1    = $signed(head.py[1]) < 1;
    sel_c    = !clip0;
    doclip_c = !head.culled && (clip0 || clip1);
    a_c[0]   = ZW'($signed(head.px[sel_c]));
    b_c[0]   = ZW'($signed(head.px[!sel_c]));
    a_c[1]   = $signed(head.zb[sel_c]);
    b_c[1]   = $signed(head.zb[!sel_c]);
    a_c[2]   = $signed(head.zt[sel_c]);
    b_c[2]   = $signed(head.zt[!sel_c]);
    da_c     = DDW'($signed(head.py[sel_c]));
    db_c     = DDW'($signed(head.py[!sel_c]));
    dd_c     = da_c - db_c;
    if (dd_c == '0) dd_c = DDW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
    end else if (en) begin
      bv_r <= {bv_r[1:0], !fifo_st.empty};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r.it   <= head;
      s0_r.sel  <= sel_c;
      s0_r.clip <= doclip_c;
      da0_r     <= da_c;
      d0_r      <= dd_c;
      s1_r      <= s0_r;
      d1_r      <= d0_r;
      s2_r      <= s1_r;
      d2_r      <= d1_r;
      for (int l = 0; l < 3; l++) begin
        a0_r[l]   <= a_c[l];
        bma0_r[l] <= BW'(b_c[l]) - BW'(a_c[l]);
        p1_r[l]   <= a0_r[l] * d0_r;
        p2_r[l]   <= da0_r * bma0_r[l];
        num_r[l]  <= p1_r[l] + p2_r[l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      num_d[l] = num_r[l];
      den_d[l] = d2_r;
    end
  end

  wvt_div #(.LN(3), .NW(PW), .DW(DDW), .SW($bits(clip_side_t))) u_clip_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (bv_r[2]),
    .num_i  (num_d),
    .den_i  (den_d),
    .side_i (s2_r),
    .vld_o  (cd_v),
    .quo_o  (cq),
    .side_o (cs_raw)
  );

  assign cs = clip_side_t'(cs_raw);

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      vx[e] = ZW'($signed(cs.it.px[e]));
      vb[e] = $signed(cs.it.zb[e]);
      vt[e] = $signed(cs.it.zt[e]);
      vy[e] = $signed(cs.it.py[e]);
      if (cs.clip && (cs.sel == e[0])) begin
        vx[e] = $signed(cq[0][ZW-1:0]);
        vb[e] = $signed(cq[1][ZW-1:0]);
        vt[e] = $signed(cq[2][ZW-1:0]);
        vy[e] = XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b3v_r <= 1'b0;
    end else if (en) begin
      b3v_r <= cd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc3_r <= cs.it.culled;
      for (int e = 0; e < 2; e++) begin
        pn_r[3*e]   <= vx[e] * SCALE;
        pn_r[3*e+1] <= vb[e] * SCALE;
        pn_r[3*e+2] <= vt[e] * SCALE;
        for (int j = 0; j < 3; j++) pd_r[3*e+j] <= vy[e];
      end
    end
  end

  wvt_div #(.LN(6), .NW(NNW), .DW(XW), .SW(1)) u_proj_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (b3v_r),
    .num_i  (pn_r),
    .den_i  (pd_r),
    .side_i (pc3_r),
    .vld_o  (pv),
    .quo_o  (pq),
    .side_o (pc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oc_r <= pc;
      for (int e = 0; e < 2; e++) begin
        for (int j = 0; j < 3; j++) begin
          o_r[3*e+j] <= pc ? 16'sd0 :
                        sat16(SATW'($signed(pq[3*e+j])) + ((j == 0) ? HW_EXT : HH_EXT));
        end
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_culled         = oc_r;
  assign out_screen_x_left  = o_r[0];
  assign out_bottom_y_left  = o_r[1];
  assign out_top_y_left     = o_r[2];
  assign out_screen_x_right = o_r[3];
  assign out_bottom_y_right = o_r[4];
  assign out_top_y_right    = o_r[5];

endmodule

>>> verif/wall_view_transform_project_top_tb.sv
module wall_view_transform_project_top_tb;

  localparam int HW = 80;
  localparam int HH = 60;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic culled;
    logic signed [15:0] sxl, sxr, byl, byr, tyl, tyr;
  } wall_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [wvt_pkg::CFG_AW-1:0] cfg_index = '0;
  logic [wvt_pkg::CFG_DW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic in_back_pass = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_culled;
  logic signed [15:0] out_screen_x_left, out_screen_x_right;
  logic signed [15:0] out_bottom_y_left, out_bottom_y_right;
  logic signed [15:0] out_top_y_left, out_top_y_right;

  wall_view_transform_project_top u_top (.*);

  initial forever #5 clk = ~clk;

  // camera state mirror
  longint m_cam_x = 0, m_cam_y = 0, m_cam_z = 0, m_cos = 16384, m_sin = 0;
  longint m_pitch = 0, m_floor = 0, m_height = 40;

  wall_res_t projected_q[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit stall_free = 1'b0;

  function automatic longint clip_toward(longint a, longint b, longint da, longint db);
    longint d;
    d = da - db;
    if (d == 0) d = 1;
    return (a * d + da * (b - a)) / d;
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic wall_res_t project_wall(logic signed [15:0] sx, logic signed [15:0] sy,
                                             logic signed [15:0] ex, logic signed [15:0] ey,
                                             logic bp);
    wall_res_t r;
    longint ax, ay, bx, by, t;
    longint px[2], py[2], zb[2], zt[2];
    int o;
    ax = longint'(sx) - m_cam_x; ay = longint'(sy) - m_cam_y;
    bx = longint'(ex) - m_cam_x; by = longint'(ey) - m_cam_y;
    if (bp) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    px[0] = (ax * m_cos - ay * m_sin) / 16384;
    px[1] = (bx * m_cos - by * m_sin) / 16384;
    py[0] = (ay * m_cos + ax * m_sin) / 16384;
    py[1] = (by * m_cos + bx * m_sin) / 16384;
    for (int i = 0; i < 2; i++) begin
      zb[i] = ((m_floor - m_cam_z) * 32 + m_pitch * py[i]) / 32;
      zt[i] = zb[i] + m_height;
    end
    r = '{1'b0, 0, 0, 0, 0, 0, 0};
    if (py[0] < 1 && py[1] < 1) begin
      r.culled = 1'b1;
      return r;
    end
    for (int i = 0; i < 2; i++) begin
      o = 1 - i;
      if (py[i] < 1) begin
        px[i] = clip_toward(px[i], px[o], py[i], py[o]);
        zb[i] = clip_toward(zb[i], zb[o], py[i], py[o]);
        zt[i] = clip_toward(zt[i], zt[o], py[i], py[o]);
        py[i] = 1;
      end
    end
    r.sxl = sat16(px[0] * 200 / py[0] + HW);
    r.sxr = sat16(px[1] * 200 / py[1] + HW);
    r.byl = sat16(zb[0] * 200 / py[0] + HH);
    r.byr = sat16(zb[1] * 200 / py[1] + HH);
    r.tyl = sat16(zt[0] * 200 / py[0] + HH);
    r.tyr = sat16(zt[1] * 200 / py[1] + HH);
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    wall_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (projected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction");
      end else begin
        e = projected_q.pop_front();
        if (out_culled !== e.culled || out_screen_x_left !== e.sxl ||
            out_screen_x_right !== e.sxr || out_bottom_y_left !== e.byl ||
            out_bottom_y_right !== e.byr || out_top_y_left !== e.tyl ||
            out_top_y_right !== e.tyr) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch exp c=%0d sx=%0d/%0d by=%0d/%0d ty=%0d/%0d",
                      " act c=%0d sx=%0d/%0d by=%0d/%0d ty=%0d/%0d"},
                     e.culled, e.sxl, e.sxr, e.byl, e.byr, e.tyl, e.tyr,
                     out_culled, out_screen_x_left, out_screen_x_right,
                     out_bottom_y_left, out_bottom_y_right, out_top_y_left, out_top_y_right);
        end
      end
    end
  end

  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (stall_free) out_stall <= 1'b0;
      else begin
        g = gap_len();
        if (g > 0) begin
          out_stall <= 1'b1;
          repeat (g) @(negedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on transactions
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // called at negedge; leaves at negedge with cfg_valid still high
  task automatic write_reg(wvt_pkg::cfg_reg_t idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      wvt_pkg::REG_CAM_X:    m_cam_x = longint'($signed(val));
      wvt_pkg::REG_CAM_Y:    m_cam_y = longint'($signed(val));
      wvt_pkg::REG_CAM_Z:    m_cam_z = longint'($signed(val));
      wvt_pkg::REG_VIEW_COS: m_cos = longint'($signed(val));
      wvt_pkg::REG_VIEW_SIN: m_sin = longint'($signed(val));
      wvt_pkg::REG_PITCH:    m_pitch = longint'($signed(val[7:0]));
      wvt_pkg::REG_FLOOR:    m_floor = longint'($signed(val));
      wvt_pkg::REG_HEIGHT:   m_height = longint'($signed(val));
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (projected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_camera(logic [15:0] cx, logic [15:0] cy, logic [15:0] cz,
                            logic [15:0] c, logic [15:0] s, logic [7:0] p,
                            logic [15:0] fl, logic [15:0] ht);
    wait_idle();
    write_reg(wvt_pkg::REG_CAM_X, cx);
    write_reg(wvt_pkg::REG_CAM_Y, cy);
    write_reg(wvt_pkg::REG_CAM_Z, cz);
    write_reg(wvt_pkg::REG_VIEW_COS, c);
    write_reg(wvt_pkg::REG_VIEW_SIN, s);
    write_reg(wvt_pkg::REG_PITCH, {8'h00, p});
    write_reg(wvt_pkg::REG_FLOOR, fl);
    write_reg(wvt_pkg::REG_HEIGHT, ht);
    cfg_valid <= 1'b0;
  endtask

  // called at negedge; leaves at negedge after acceptance
  task automatic send_wall(logic signed [15:0] sx, logic signed [15:0] sy,
                           logic signed [15:0] ex, logic signed [15:0] ey, logic bp);
    int g;
    g = stall_free ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_start_x <= sx; in_start_y <= sy; in_end_x <= ex; in_end_y <= ey;
    in_back_pass <= bp;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    projected_q.push_back(project_wall(sx, sy, ex, ey, bp));
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] near_val();
    return $signed(16'($urandom_range(400)) - 16'sd200);
  endfunction

  task automatic test_directed();
    send_wall(10, 50, -10, 60, 0);
    send_wall(10, 50, -10, 60, 1);
    send_wall(10, -5, -10, -20, 0);           // both behind
    send_wall(10, 0, 20, 1, 0);               // depths 0 and 1 edge
    send_wall(-30, -40, 30, 80, 0);           // first behind, clipped
    send_wall(-30, 80, 30, -40, 0);           // second behind, clipped
    send_wall(-30, 80, 30, -40, 1);
    send_wall(32767, 32767, -32768, 32767, 0);
    send_wall(-32768, -32768, 32767, -32768, 1);
    send_wall(32767, 1, -32768, 1, 0);        // saturation
    send_wall(0, 1, 0, 1, 0);
    send_wall(-32768, 32767, 32767, -32768, 0);
    send_wall(-32768, 32767, 32767, -32768, 1);
    end_burst();
    set_camera(16'h8000, 16'h8000, 16'h7fff, 16'hc000, 16'h4000, 8'h80, 16'h8000, 16'h8000);
    send_wall(32767, 32767, -32768, 32767, 0);
    send_wall(-32768, -32768, 32767, 0, 1);
    send_wall(100, -200, -300, 400, 0);
    end_burst();
    set_camera(16'h7fff, 16'h7fff, 16'h8000, 16'h4000, 16'hc000, 8'h7f, 16'h7fff, 16'h7fff);
    send_wall(-32768, -32768, 32767, 32767, 0);
    send_wall(32767, -32768, -32768, 32767, 1);
    send_wall(0, 0, 1000, -1000, 0);
    end_burst();
  endtask

  task automatic test_random_phase(int n);
    logic signed [15:0] v[4];
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 4; k++)
        v[k] = ($urandom_range(3) == 0) ? 16'($urandom) : near_val();
      send_wall(v[0], v[1], v[2], v[3], 1'($urandom));
    end
    end_burst();
  endtask

  task automatic test_random();
    int c, s;
    for (int ph = 0; ph < 6; ph++) begin
      c = $urandom_range(32768) - 16384;
      s = $urandom_range(32768) - 16384;
      if (ph == 0) begin c = 16384; s = 0; end
      stall_free = (ph == 3);
      set_camera(16'($urandom_range(200) - 100), 16'($urandom_range(200) - 100),
                 16'($urandom_range(100) - 50), 16'(c), 16'(s), 8'($urandom),
                 16'($urandom_range(100) - 50),
                 (ph == 5) ? 16'($urandom) : 16'($urandom_range(80)));
      test_random_phase(240);
    end
    stall_free = 1'b0;
    set_camera(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(32768) - 16384),
               16'($urandom_range(32768) - 16384), 8'($urandom), 16'($urandom), 16'($urandom));
    test_random_phase(100);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random();
    wait_idle();
    if (mismatches == 0 && projected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> wall_view_transform_project_top.f
+incdir+design
design/wvt_pkg.sv
design/wvt_div.sv
design/wvt_front.sv
design/wvt_fifo.sv
design/wvt_back.sv
design/wall_view_transform_project_top.sv
verif/wall_view_transform_project_top_tb.sv
